[sv/paced_velocity_command_packer_unit_macros.svh]
// Assertion helpers shared by the packer modules.
`ifndef PACED_VELOCITY_COMMAND_PACKER_UNIT_MACROS_SVH
`define PACED_VELOCITY_COMMAND_PACKER_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define PVCP_ASSERT_NOW(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define PVCP_ASSERT_NEXT(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/pvcp_pkg.sv]
package pvcp_pkg;

	// func codes
	localparam logic [1:0] FUNC_STEP  = 2'd0;
	localparam logic [1:0] FUNC_ENTER = 2'd1;
	localparam logic [1:0] FUNC_EXIT  = 2'd2;

	// register indexes
	localparam logic [2:0] CFG_GEAR_RATIO     = 3'd0;
	localparam logic [2:0] CFG_INVERT_DIR     = 3'd1;
	localparam logic [2:0] CFG_FALLBACK_ACCEL = 3'd2;
	localparam logic [2:0] CFG_BUS_ID         = 3'd3;
	localparam logic [2:0] CFG_OPCODE_BYTE    = 3'd4;
	localparam logic [2:0] CFG_DEFAULT_PERIOD = 3'd5;

	// register reset values
	localparam logic [23:0] RST_GEAR_RATIO     = 24'd65536;
	localparam logic        RST_INVERT_DIR     = 1'b0;
	localparam logic [7:0]  RST_FALLBACK_ACCEL = 8'd0;
	localparam logic [10:0] RST_BUS_ID         = 11'd1;
	localparam logic [7:0]  RST_OPCODE_BYTE    = 8'd246;
	localparam logic [31:0] RST_DEFAULT_PERIOD = 32'd5000000;

	localparam int PVCP_QUEUE_DEPTH = 4;

	// speed math: rpm = floor((mag + 3*2^24) / (6*2^24)), clamped
	localparam logic [48:0] RPM_HALF_STEP = 49'd50331648;
	localparam logic [23:0] RPM_CLAMP_T   = 24'd9003;   // t/3 > 3000 from here
	localparam logic [11:0] SPEED_MAX_RPM = 12'd3000;
	localparam logic [14:0] DIV3_RECIP    = 15'd21846;  // 2^16/3, exact for t < 9003
	localparam logic [7:0]  DIR_NEG       = 8'h80;

	// accel math: floor((min(a,25600)*255 + 12800) / 25600)
	localparam logic [14:0] ACCEL_FULL_Q8 = 15'd25600;
	localparam logic [22:0] ACCEL_SCALE   = 23'd255;
	localparam logic [22:0] ACCEL_HALF    = 23'd12800;
	localparam logic [14:0] DIV100_RECIP  = 15'd20972;  // 2^21/100 rounded up

	typedef struct packed {
		logic [23:0] gear_ratio;
		logic        reverse_dir;
		logic [7:0]  fallback_accel;
		logic [10:0] bus_id;
		logic [7:0]  opcode_byte;
		logic [31:0] default_period;
	} cfg_t;

	// one classified item, front to back
	typedef struct packed {
		logic        cmd_emitted;
		logic        point_taken;
		logic        bad_ratio;
		logic [23:0] velocity;
		logic [15:0] acceleration;
	} cmd_rec_t;

endpackage

[sv/pvcp_front.sv]
module pvcp_front import pvcp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [63:0] now_ns,
	input  logic        point_valid,
	input  logic [23:0] velocity,
	input  logic [15:0] acceleration,
	input  logic [31:0] step_period,
	input  logic        q_full,
	output logic        push,
	output cmd_rec_t    push_rec
);

	logic        pending_q;
	logic [63:0] next_emit_q;
	logic [23:0] held_velocity_q;
	logic [15:0] held_accel_q;
	logic [31:0] held_period_q;

	logic        is_step, taken, live, due, emit, ratio_zero;
	logic [63:0] eff_next, sat_sum, advanced;
	logic [31:0] eff_period, period;
	logic [64:0] sum;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		is_step    = (func == FUNC_STEP);
		taken      = is_step && !pending_q && point_valid;
		live       = pending_q || taken;
		eff_next   = taken ? now_ns : next_emit_q;
		due        = live && (taken || (now_ns >= next_emit_q));
		ratio_zero = (cfg.gear_ratio == '0);
		emit       = is_step && due && !ratio_zero;
		eff_period = taken ? step_period : held_period_q;
		period     = (eff_period != '0) ? eff_period : cfg.default_period;
		sum        = {1'b0, eff_next} + {33'b0, period};
		sat_sum    = sum[64] ? '1 : sum[63:0];
		advanced   = (sat_sum < now_ns) ? now_ns : sat_sum;

		push_rec.cmd_emitted  = emit;
		push_rec.point_taken  = taken;
		push_rec.bad_ratio    = is_step && due && ratio_zero;
		push_rec.velocity     = taken ? velocity : held_velocity_q;
		push_rec.acceleration = taken ? acceleration : held_accel_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= 1'b0;
			next_emit_q <= '0;
		end else if (push) begin
			case (func)
				FUNC_ENTER: begin
					pending_q   <= 1'b0;
					next_emit_q <= now_ns;
				end
				FUNC_EXIT: begin
					pending_q   <= 1'b0;
					next_emit_q <= '0;
				end
				FUNC_STEP: begin
					if (emit) begin
						pending_q   <= 1'b0;
						next_emit_q <= advanced;
					end else if (taken) begin
						pending_q   <= 1'b1;
						next_emit_q <= now_ns;
					end
				end
				default: ;
			endcase
		end
	end

	// held setpoint, written only when taken
	always_ff @(posedge clk) begin
		if (push && taken) begin
			held_velocity_q <= velocity;
			held_accel_q    <= acceleration;
			held_period_q   <= step_period;
		end
	end

endmodule

[sv/pvcp_queue.sv]
`include "paced_velocity_command_packer_unit_macros.svh"

module pvcp_queue import pvcp_pkg::*; #(
	parameter int DEPTH = PVCP_QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  cmd_rec_t push_rec,
	input  logic     pop,
	output cmd_rec_t head_rec,
	output logic     full,
	output logic     empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_rec_t           mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign head_rec = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= bump(wr_ptr_q);
			if (pop)  rd_ptr_q <= bump(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_rec;
	end

	`PVCP_ASSERT_NOW(a_pop_has_data, clk, arst_n, pop, !empty, "queue popped while empty")
	`PVCP_ASSERT_NOW(a_push_has_room, clk, arst_n, push, !full, "queue pushed while full")

endmodule

[sv/pvcp_back.sv]
`include "paced_velocity_command_packer_unit_macros.svh"

module pvcp_back import pvcp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  cmd_rec_t    head_rec,
	input  logic        q_empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        cmd_emitted,
	output logic        point_taken,
	output logic        bad_ratio,
	output logic [10:0] cmd_id,
	output logic [7:0]  cmd_code,
	output logic [7:0]  dir_speed_high,
	output logic [7:0]  speed_low,
	output logic [7:0]  accel_out
);

	logic en1, en2;

	// stage 1: magnitude product and scaled accel
	logic        valid_s1, has_s1, taken_s1, bad_s1, neg_s1, apos_s1;
	logic [47:0] mag_s1;
	logic [14:0] accu_s1;

	logic [24:0] v25, absv25;
	logic [23:0] absv;
	logic        neg;
	logic [47:0] mag;
	logic        apos;
	logic [14:0] amin;
	logic [22:0] ascaled;

	// stage 2: output register
	logic        valid_s2, has_s2, taken_s2, bad_s2, neg_s2;
	logic [11:0] rpm_s2;
	logic [7:0]  accel_s2;

	logic [48:0] rounded;
	logic [23:0] t3;
	logic [28:0] div3;
	logic [29:0] div100;
	logic [11:0] rpm;
	logic [7:0]  accel_code;

	assign en2 = !valid_s2 || out_ready;
	assign en1 = !valid_s1 || en2;
	assign pop = !q_empty && en1;

	always_comb begin
		v25     = {head_rec.velocity[23], head_rec.velocity};
		absv25  = v25[24] ? -v25 : v25;
		absv    = absv25[23:0];
		// reversal flips only the sign; zero speed never counts as reverse
		neg     = (head_rec.velocity != '0) && (v25[24] ^ cfg.reverse_dir);
		mag     = {24'b0, absv} * {24'b0, cfg.gear_ratio};
		apos    = !head_rec.acceleration[15] && (head_rec.acceleration != '0);
		amin    = (head_rec.acceleration[14:0] > ACCEL_FULL_Q8) ? ACCEL_FULL_Q8
			: head_rec.acceleration[14:0];
		ascaled = {8'b0, amin} * ACCEL_SCALE + ACCEL_HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (en1) valid_s1 <= !q_empty;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			has_s1   <= head_rec.cmd_emitted;
			taken_s1 <= head_rec.point_taken;
			bad_s1   <= head_rec.bad_ratio;
			neg_s1   <= neg;
			mag_s1   <= mag;
			apos_s1  <= apos;
			accu_s1  <= ascaled[22:8];
		end
	end

	// t = floor((mag + half) / 2^25); rpm = t / 3 via reciprocal
	always_comb begin
		rounded    = {1'b0, mag_s1} + RPM_HALF_STEP;
		t3         = rounded[48:25];
		div3       = {15'b0, t3[13:0]} * {14'b0, DIV3_RECIP};
		rpm        = (t3 >= RPM_CLAMP_T) ? SPEED_MAX_RPM : div3[27:16];
		div100     = {15'b0, accu_s1} * {15'b0, DIV100_RECIP};
		accel_code = apos_s1 ? div100[28:21] : cfg.fallback_accel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (en2) valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			has_s2   <= has_s1;
			taken_s2 <= taken_s1;
			bad_s2   <= bad_s1;
			neg_s2   <= neg_s1 && has_s1;
			rpm_s2   <= has_s1 ? rpm : '0;
			accel_s2 <= has_s1 ? accel_code : '0;
		end
	end

	assign out_valid      = valid_s2;
	assign cmd_emitted    = has_s2;
	assign point_taken    = taken_s2;
	assign bad_ratio      = bad_s2;
	assign cmd_id         = has_s2 ? cfg.bus_id : '0;
	assign cmd_code       = has_s2 ? cfg.opcode_byte : '0;
	assign dir_speed_high = (neg_s2 ? DIR_NEG : 8'h00) | {4'b0, rpm_s2[11:8]};
	assign speed_low      = rpm_s2[7:0];
	assign accel_out      = accel_s2;

	`PVCP_ASSERT_NOW(a_rpm_clamped, clk, arst_n, valid_s2, rpm_s2 <= SPEED_MAX_RPM, "rpm above limit")
	`PVCP_ASSERT_NOW(a_cmd_xor_bad, clk, arst_n, valid_s2, !(has_s2 && bad_s2), "command with bad ratio")

endmodule

[sv/paced_velocity_command_packer_unit.sv]
// Paced velocity command packer. Each item carries the time (now_ns), a func
// code and optionally a velocity setpoint; every item yields exactly one
// result item. One setpoint is held at a time; once its emit time is due the
// block emits a speed-mode command (id, code, direction plus 12-bit rpm,
// accel byte) and moves the emit time on by the setpoint period, or by
// default_period when that period is zero. A zero gear ratio sets
// bad_ratio and keeps the setpoint pending. Rate: one item per clock, as long
// as the result side keeps up; in_ready drops only when the small item queue
// between front and back is full. The figure rests on the front computing
// its emit-time update combinationally (a 64-bit add with saturation and two
// compares). An item passes through the queue and the stage-1 and stage-2
// registers before its result is valid. Configuration is written through
// cfg_we/cfg_index/cfg_data and must be done while no item is in flight.
module paced_velocity_command_packer_unit import pvcp_pkg::*; #(
	parameter int QUEUE_DEPTH = PVCP_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// input items
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic [63:0]        now_ns,
	input  logic               point_valid,
	input  logic signed [23:0] velocity,
	input  logic signed [15:0] acceleration,
	input  logic [31:0]        step_period,
	// result items
	output logic               out_valid,
	input  logic               out_ready,
	output logic               cmd_emitted,
	output logic               point_taken,
	output logic               bad_ratio,
	output logic [10:0]        cmd_id,
	output logic [7:0]         cmd_code,
	output logic [7:0]         dir_speed_high,
	output logic [7:0]         speed_low,
	output logic [7:0]         accel_out
);

	cfg_t     cfg_q;
	logic     push, pop, q_full, q_empty;
	cmd_rec_t push_rec, head_rec;

	// configuration registers; index out of the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gear_ratio     <= RST_GEAR_RATIO;
			cfg_q.reverse_dir    <= RST_INVERT_DIR;
			cfg_q.fallback_accel <= RST_FALLBACK_ACCEL;
			cfg_q.bus_id         <= RST_BUS_ID;
			cfg_q.opcode_byte    <= RST_OPCODE_BYTE;
			cfg_q.default_period <= RST_DEFAULT_PERIOD;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GEAR_RATIO:     cfg_q.gear_ratio     <= cfg_data[23:0];
				CFG_INVERT_DIR:     cfg_q.reverse_dir    <= cfg_data[0];
				CFG_FALLBACK_ACCEL: cfg_q.fallback_accel <= cfg_data[7:0];
				CFG_BUS_ID:         cfg_q.bus_id         <= cfg_data[10:0];
				CFG_OPCODE_BYTE:    cfg_q.opcode_byte    <= cfg_data[7:0];
				CFG_DEFAULT_PERIOD: cfg_q.default_period <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: owns pending flag, emit time and held setpoint; decides per item
	pvcp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.now_ns       (now_ns),
		.point_valid  (point_valid),
		.velocity     (velocity),
		.acceleration (acceleration),
		.step_period  (step_period),
		.q_full       (q_full),
		.push         (push),
		.push_rec     (push_rec)
	);

	// decoupling queue of classified items
	pvcp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head_rec (head_rec),
		.full     (q_full),
		.empty    (q_empty)
	);

	// back: speed/accel arithmetic in two stages, output register last
	pvcp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.head_rec       (head_rec),
		.q_empty        (q_empty),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cmd_emitted    (cmd_emitted),
		.point_taken    (point_taken),
		.bad_ratio      (bad_ratio),
		.cmd_id         (cmd_id),
		.cmd_code       (cmd_code),
		.dir_speed_high (dir_speed_high),
		.speed_low      (speed_low),
		.accel_out      (accel_out)
	);

endmodule
